// ===== rtl/core/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and the divide-by-255 helpers for HSV to RGB.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int IDX_W   = 10;
    localparam int HUE_W   = 16;
    localparam int CH_W    = 8;
    localparam int NUM_STG = 5;

    // slave tdata: led_index, hue, saturation, brightness_value (42 bits used)
    localparam int IN_W  = 48;
    // master tdata: out_index, red, green, blue (34 bits used)
    localparam int OUT_W = 40;

    // 255 * 65536, the full-scale product of s and the 0.16 fraction
    localparam logic [23:0] DENOM = 24'd16711680;
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    // hue sectors
    localparam logic [2:0] SEC_RED_YEL   = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN   = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU   = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG   = 3'd4;

    // floor(y/255) estimate via y*257/65536; low by at most one
    function automatic logic [7:0] f_div255_est(input logic [15:0] y);
        logic [23:0] m;
        m = 24'(y) * 24'd257;
        return m[23:16];
    endfunction

    // one compare-and-step correction of the estimate
    function automatic logic [7:0] f_div255_fix(input logic [15:0] y, input logic [7:0] qe);
        logic [15:0] rem;
        rem = y - 16'(qe) * 16'd255;
        return (rem >= 16'd255) ? qe + 8'd1 : qe;
    endfunction

endpackage

// ===== rtl/core/hsv_to_rgb_converter_unit.sv =====
// Each pixel passes through stage 1, stages 2 to 4 and the output register in order;
//   output valid is the valid bit of the output register.
// Throughput: one pixel per clock; a five-register pipeline with valid bits,
//   each stage advances when it is empty or the next stage moves.
// Output stalls back up only as far as the pipeline is full.
// Reset (synchronous, active low) clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Six-sector HSV to RGB conversion with exact fixed-point divides by 255.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [9:0] led_index, [25:10] hue, [33:26] saturation, [41:34] brightness_value
    input  logic [hsv2rgb_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [9:0] out_index, [17:10] red, [25:18] green, [33:26] blue
    output logic [hsv2rgb_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import hsv2rgb_pkg::*;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_rdy;

    // stage 1
    logic [IDX_W-1:0] r_s1_idx;
    logic [2:0]       r_s1_sec;
    logic [15:0]      r_s1_f;
    logic [15:0]      r_s1_pp;
    logic [CH_W-1:0]  r_s1_s, r_s1_v;
    // stage 2
    logic [IDX_W-1:0] r_s2_idx;
    logic [2:0]       r_s2_sec;
    logic [23:0]      r_s2_fs;
    logic [24:0]      r_s2_gs;
    logic [15:0]      r_s2_pp;
    logic [7:0]       r_s2_pe;
    logic [CH_W-1:0]  r_s2_v;
    // stage 3
    logic [IDX_W-1:0] r_s3_idx;
    logic [2:0]       r_s3_sec;
    logic [31:0]      r_s3_mq, r_s3_mt;
    logic [CH_W-1:0]  r_s3_p, r_s3_v;
    // stage 4
    logic [IDX_W-1:0] r_s4_idx;
    logic [2:0]       r_s4_sec;
    logic [15:0]      r_s4_yq, r_s4_yt;
    logic [7:0]       r_s4_qe, r_s4_te;
    logic [CH_W-1:0]  r_s4_p, r_s4_v;
    // output stage
    logic [IDX_W-1:0] r_o_idx;
    logic [CH_W-1:0]  r_o_red, r_o_grn, r_o_blu;

    // input unpack
    logic [IDX_W-1:0] w_idx;
    logic [HUE_W-1:0] w_hue;
    logic [CH_W-1:0]  w_sat, w_val;
    logic [18:0]      w_six;

    logic [IDX_W-1:0] n_s1_idx;
    logic [2:0]       n_s1_sec;
    logic [15:0]      n_s1_f, n_s1_pp;
    logic [23:0]      n_s2_fs;
    logic [24:0]      n_s2_gs;
    logic [7:0]       n_s2_pe;
    logic [24:0]      w_xt;
    logic [23:0]      w_xq;
    logic [31:0]      n_s3_mq, n_s3_mt;
    logic [CH_W-1:0]  n_s3_p;
    logic [7:0]       n_s4_qe, n_s4_te;
    logic [CH_W-1:0]  n_q, n_t;
    logic [CH_W-1:0]  n_o_red, n_o_grn, n_o_blu;

    // stage k moves when it is empty or stage k+1 moves
    always_comb begin
        w_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_m_axis_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NUM_STG-1];
    assign o_m_axis_tdata  = {6'd0, r_o_blu, r_o_grn, r_o_red, r_o_idx};

    always_comb begin
        w_idx = i_s_axis_tdata[9:0];
        w_hue = i_s_axis_tdata[25:10];
        w_sat = i_s_axis_tdata[33:26];
        w_val = i_s_axis_tdata[41:34];
        w_six = 19'(w_hue) * 19'd6;
        n_s1_idx = w_idx;
        n_s1_sec = w_six[18:16];
        n_s1_f   = w_six[15:0];
        n_s1_pp  = 16'(w_val) * (16'd255 - 16'(w_sat));
    end

    always_comb begin
        n_s2_fs = 24'(r_s1_f) * 24'(r_s1_s);
        n_s2_gs = (25'(FRAC_ONE) - 25'(r_s1_f)) * 25'(r_s1_s);
        n_s2_pe = f_div255_est(r_s1_pp);
    end

    always_comb begin
        w_xq    = DENOM - r_s2_fs;
        w_xt    = 25'(DENOM) - r_s2_gs;
        n_s3_mq = 32'(r_s2_v) * 32'(w_xq);
        n_s3_mt = 32'(r_s2_v) * 32'(w_xt[23:0]);
        n_s3_p  = f_div255_fix(r_s2_pp, r_s2_pe);
    end

    always_comb begin
        n_s4_qe = f_div255_est(r_s3_mq[31:16]);
        n_s4_te = f_div255_est(r_s3_mt[31:16]);
    end

    always_comb begin
        n_q = f_div255_fix(r_s4_yq, r_s4_qe);
        n_t = f_div255_fix(r_s4_yt, r_s4_te);
        case (r_s4_sec)
            SEC_RED_YEL: begin
                n_o_red = r_s4_v; n_o_grn = n_t;    n_o_blu = r_s4_p;
            end
            SEC_YEL_GRN: begin
                n_o_red = n_q;    n_o_grn = r_s4_v; n_o_blu = r_s4_p;
            end
            SEC_GRN_CYN: begin
                n_o_red = r_s4_p; n_o_grn = r_s4_v; n_o_blu = n_t;
            end
            SEC_CYN_BLU: begin
                n_o_red = r_s4_p; n_o_grn = n_q;    n_o_blu = r_s4_v;
            end
            SEC_BLU_MAG: begin
                n_o_red = n_t;    n_o_grn = r_s4_p; n_o_blu = r_s4_v;
            end
            default: begin
                n_o_red = r_s4_v; n_o_grn = r_s4_p; n_o_blu = n_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_idx <= n_s1_idx;
            r_s1_sec <= n_s1_sec;
            r_s1_f   <= n_s1_f;
            r_s1_pp  <= n_s1_pp;
            r_s1_s   <= w_sat;
            r_s1_v   <= w_val;
        end
        if (w_rdy[1]) begin
            r_s2_idx <= r_s1_idx;
            r_s2_sec <= r_s1_sec;
            r_s2_fs  <= n_s2_fs;
            r_s2_gs  <= n_s2_gs;
            r_s2_pp  <= r_s1_pp;
            r_s2_pe  <= n_s2_pe;
            r_s2_v   <= r_s1_v;
        end
        if (w_rdy[2]) begin
            r_s3_idx <= r_s2_idx;
            r_s3_sec <= r_s2_sec;
            r_s3_mq  <= n_s3_mq;
            r_s3_mt  <= n_s3_mt;
            r_s3_p   <= n_s3_p;
            r_s3_v   <= r_s2_v;
        end
        if (w_rdy[3]) begin
            r_s4_idx <= r_s3_idx;
            r_s4_sec <= r_s3_sec;
            r_s4_yq  <= r_s3_mq[31:16];
            r_s4_yt  <= r_s3_mt[31:16];
            r_s4_qe  <= n_s4_qe;
            r_s4_te  <= n_s4_te;
            r_s4_p   <= r_s3_p;
            r_s4_v   <= r_s3_v;
        end
        if (w_rdy[4]) begin
            r_o_idx <= r_s4_idx;
            r_o_red <= n_o_red;
            r_o_grn <= n_o_grn;
            r_o_blu <= n_o_blu;
        end
    end

    // an empty output register means the whole chain can move
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NUM_STG-1] |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    // corrected p never exceeds v
    a_p_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_p <= r_s3_v))
        else $error("p above value");

    // corrected q and t never exceed v
    a_qt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> ((n_q <= r_s4_v) && (n_t <= r_s4_v)))
        else $error("q or t above value");

    // a stalled output register keeps its item across the stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STG-1] && !i_m_axis_tready) |=> r_vld[NUM_STG-1])
        else $error("output item lost during stall");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for hsv_to_rgb_converter_unit. Pixels go in with random
// input gaps and output backpressure; each output transfer is checked field by
// field against a bit-exact fixed-point HSV to RGB predictor.
// ----------------------------------------------------------------------------
module tb;
    import hsv2rgb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 30;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_rgb_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    // [9:0] led_index, [25:10] hue, [33:26] saturation, [41:34] brightness_value
    logic [IN_W-1:0] s_data = '0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    // [9:0] out_index, [17:10] red, [25:18] green, [33:26] blue
    logic [OUT_W-1:0] m_data;

    bit gaps_on = 1'b1;
    int mismatches = 0;
    int cycle_count = 0;
    t_rgb_pixel expected_pixels[$];

    hsv_to_rgb_converter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // six-sector conversion with exact truncating divides
    function automatic t_rgb_pixel predict_rgb(input logic [IDX_W-1:0] idx,
                                               input logic [HUE_W-1:0] hue,
                                               input logic [CH_W-1:0]  sat,
                                               input logic [CH_W-1:0]  val);
        logic [18:0] six;
        logic [2:0] sector;
        longint unsigned f, s, v, den, p, q, t;
        t_rgb_pixel px;
        six    = 19'(hue) * 19'd6;
        sector = six[18:16];
        f      = 64'(six[15:0]);
        s      = 64'(sat);
        v      = 64'(val);
        den    = 64'(DENOM);
        p = (v * (255 - s)) / 255;
        q = (v * (den - f * s)) / den;
        t = (v * (den - (FRAC_ONE - f) * s)) / den;
        px.index = idx;
        case (sector)
            SEC_RED_YEL: begin px.red = 8'(v); px.green = 8'(t); px.blue = 8'(p); end
            SEC_YEL_GRN: begin px.red = 8'(q); px.green = 8'(v); px.blue = 8'(p); end
            SEC_GRN_CYN: begin px.red = 8'(p); px.green = 8'(v); px.blue = 8'(t); end
            SEC_CYN_BLU: begin px.red = 8'(p); px.green = 8'(q); px.blue = 8'(v); end
            SEC_BLU_MAG: begin px.red = 8'(t); px.green = 8'(p); px.blue = 8'(v); end
            default:     begin px.red = 8'(v); px.green = 8'(p); px.blue = 8'(q); end
        endcase
        return px;
    endfunction

    always @(posedge i_clk) begin : check_output
        t_rgb_pixel want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("output transfer with nothing pending: %h", m_data);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_data[9:0] !== want.index) begin
                    $error("out_index: expected %0d, got %0d", want.index, m_data[9:0]);
                    mismatches++;
                end
                if (m_data[17:10] !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, m_data[17:10]);
                    mismatches++;
                end
                if (m_data[25:18] !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, m_data[25:18]);
                    mismatches++;
                end
                if (m_data[33:26] !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, m_data[33:26]);
                    mismatches++;
                end
            end
        end
    end

    // valid stays high into the next call; callers drop it with stop_input
    task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [HUE_W-1:0] hue,
                              input logic [CH_W-1:0] sat, input logic [CH_W-1:0] val);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {6'd0, val, sat, hue, idx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        expected_pixels.push_back(predict_rgb(idx, hue, sat, val));
    endtask

    task automatic stop_input();
        s_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // leans toward 0 and full scale now and then
    function automatic logic [CH_W-1:0] rand_level();
        case ($urandom_range(0, 15))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                       rand_level(), rand_level());
    endtask

    task automatic test_directed();
        // extremes of every field
        send_pixel(10'd0,    16'd0,     8'd0,   8'd0);
        send_pixel(10'd1023, 16'd65535, 8'd255, 8'd255);
        send_pixel(10'd512,  16'd0,     8'd255, 8'd255);
        send_pixel(10'd341,  16'd65535, 8'd0,   8'd255);
        // zero saturation gives grey
        send_pixel(10'd682,  16'd30000, 8'd0,   8'd173);
        // both sides of each sector boundary
        send_pixel(10'd1,    16'd10922, 8'd255, 8'd255);
        send_pixel(10'd2,    16'd10923, 8'd255, 8'd255);
        send_pixel(10'd3,    16'd21845, 8'd200, 8'd255);
        send_pixel(10'd4,    16'd21846, 8'd200, 8'd255);
        send_pixel(10'd5,    16'd32767, 8'd255, 8'd128);
        send_pixel(10'd6,    16'd32768, 8'd255, 8'd128);
        send_pixel(10'd7,    16'd43690, 8'd128, 8'd255);
        send_pixel(10'd8,    16'd43691, 8'd128, 8'd255);
        send_pixel(10'd9,    16'd54613, 8'd255, 8'd77);
        send_pixel(10'd10,   16'd54614, 8'd255, 8'd77);
        // mid-sector, every sector
        send_pixel(10'd100,  16'd5461,  8'd170, 8'd200);
        send_pixel(10'd200,  16'd16384, 8'd170, 8'd200);
        send_pixel(10'd300,  16'd27306, 8'd170, 8'd200);
        send_pixel(10'd400,  16'd38229, 8'd170, 8'd200);
        send_pixel(10'd500,  16'd49152, 8'd170, 8'd200);
        send_pixel(10'd600,  16'd60074, 8'd170, 8'd200);
        send_pixel(10'h2AA,  16'hAAAA,  8'hAA,  8'h55);
        send_pixel(10'h155,  16'h5555,  8'h55,  8'hAA);
        stop_input();
    endtask

    task automatic test_random_gaps();
        send_random(600);
        stop_input();
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        send_random(250);
        stop_input();
        gaps_on = 1'b1;
    endtask

    // sender holds off until the pipeline has fully drained, then resumes
    task automatic test_drain_pause();
        send_random(80);
        stop_input();
        wait_drained();
        send_random(50);
        stop_input();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_gaps();
        test_full_rate();
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== hsv_to_rgb_converter_unit.f =====
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter_unit.sv
verif/tb.sv
